[design/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

  localparam int GROUP_WORDS = 1024;
  localparam int MAP_GROUPS  = 4;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = GROUP_WORDS * MAP_GROUPS;
  localparam int MAP_BITS    = MAP_WORDS * WORD_BITS;

  localparam int BIT_AW  = $clog2(WORD_BITS);
  localparam int WORD_AW = $clog2(MAP_WORDS);
  localparam int GW_AW   = $clog2(GROUP_WORDS);
  localparam int GRP_AW  = $clog2(MAP_GROUPS);

  localparam int BLK_W  = 17;
  localparam int CNT_W  = 18;
  localparam int LEN_W  = 13;
  localparam int RES_W  = 13;
  localparam int MODE_W = 2;
  localparam int ST_W   = 2;
  localparam int CIDX_W = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CIDX_W-1:0] REG_TOTAL    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RESERVED = 2'd1;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAP_BITS);

  // bits below n set
  function automatic word_t low_mask(input logic [BIT_AW-1:0] n);
    low_mask = (word_t'(1) << n) - word_t'(1);
  endfunction

endpackage

[design/block_bitmap_allocator.sv]
`timescale 1ns / 1ps
// Next-fit block allocator over a 4096 x 32-bit usage bitmap held in one
// synchronous RAM, with a next-fit hint and a free-block count.
// Input channel (in_valid / in_stall): one request beat carries mode,
// block_number and run_length. in_stall is high whenever a request is in work.
// Output channel (out_valid / out_stall): exactly one result beat per request,
// held in an output register; a request is accepted while an earlier result
// still waits, and the block holds its finished result until the slot frees.
// Work per request, on the one-read-one-write bitmap RAM:
//   allocate: scans words from the hint's group start
//             (up to 4096, one read per cycle, pipelined)
//   free:     reads then writes each word touched by the run
//   format:   writes all 4096 words (one word written per cycle)
//   rejected requests and unused mode: no RAM access
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user only
// while idle; the block does not enforce it. Index 0 total_blocks, index 1
// reserved_count. After reset all 4096 RAM words are swept to zero while
// in_stall stays high; free count and hint are zero, so allocate answers
// no space until a format or a free.
module block_bitmap_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bba_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CNT_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bba_pkg::MODE_W-1:0]   in_mode,
  input  logic [bba_pkg::BLK_W-1:0]    in_block_number,
  input  logic [bba_pkg::LEN_W-1:0]    in_run_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bba_pkg::BLK_W-1:0]    out_allocated_block,
  output logic [bba_pkg::ST_W-1:0]     out_status,
  output logic [bba_pkg::CNT_W-1:0]    out_free_count
);
  import bba_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_FMT  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FWR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
  localparam logic [WORD_AW:0]   ALL_WORDS = (WORD_AW+1)'(MAP_WORDS);

  // bitmap ram
  word_t               mem [MAP_WORDS];
  word_t               rd_data_r;
  logic                rd_en;
  logic [WORD_AW-1:0]  rd_addr;
  logic                wr_en;
  logic [WORD_AW-1:0]  wr_addr;
  word_t               wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [RES_W-1:0]    resv_r, resv_nxt;
  logic [BLK_W-1:0]    hint_r, hint_nxt;
  logic [CNT_W-1:0]    free_r, free_nxt;
  logic [WORD_AW-1:0]  cur_r, cur_nxt;
  logic [WORD_AW:0]    issued_r, issued_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [WORD_AW-1:0]  chk_addr_r, chk_addr_nxt;
  logic [BLK_W-1:0]    first_r, first_nxt;
  logic [BLK_W-1:0]    last_r, last_nxt;
  logic [BLK_W-1:0]    res_blk_r, res_blk_nxt;
  logic [ST_W-1:0]     res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]    out_blk_r, out_blk_nxt;
  logic [ST_W-1:0]     out_st_r, out_st_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0]    eff;
  logic [CNT_W-1:0]    run_end;
  logic [CNT_W-1:0]    free_sum;
  logic [BLK_W-1:0]    run_last;
  logic                accept;
  word_t               fmt_word;
  word_t               clr_mask;
  logic [BIT_AW-1:0]   zbit;
  logic [BIT_AW-1:0]   lo_bit, hi_bit;
  logic [RES_W-BIT_AW-1:0]  resv_word;
  logic [CNT_W-BIT_AW-1:0]  eff_word;
  logic [CNT_W-BIT_AW-1:0]  cur_ext;

  assign eff      = (total_r > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : total_r;
  assign run_end  = CNT_W'(in_block_number) + CNT_W'(in_run_length);
  assign free_sum = free_r + CNT_W'(in_run_length);
  assign run_last = in_block_number + BLK_W'(in_run_length) - BLK_W'(1);
  assign accept   = in_valid && (state_r == S_IDLE);

  assign resv_word = resv_r[RES_W-1:BIT_AW];
  assign eff_word  = eff[CNT_W-1:BIT_AW];
  assign cur_ext   = (CNT_W-BIT_AW)'(cur_r);

  // format pattern: reserved head and blocks past the total are used
  always_comb begin
    word_t r_mask, e_mask;
    r_mask = '0;
    e_mask = '0;
    if (cur_ext < (CNT_W-BIT_AW)'(resv_word)) begin
      r_mask = '1;
    end else if (cur_ext == (CNT_W-BIT_AW)'(resv_word)) begin
      r_mask = low_mask(resv_r[BIT_AW-1:0]);
    end
    if (cur_ext > eff_word) begin
      e_mask = '1;
    end else if (cur_ext == eff_word) begin
      e_mask = ~low_mask(eff[BIT_AW-1:0]);
    end
    fmt_word = r_mask | e_mask;
  end

  // bits of the current word that the freed run covers
  always_comb begin
    lo_bit   = (cur_r == first_r[BLK_W-1:BIT_AW]) ? first_r[BIT_AW-1:0] : '0;
    hi_bit   = (cur_r == last_r[BLK_W-1:BIT_AW])  ? last_r[BIT_AW-1:0]  : '1;
    clr_mask = (word_t'('1) << lo_bit) & (word_t'('1) >> (~hi_bit));
  end

  always_comb begin
    zbit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_r[i]) begin
        zbit = BIT_AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    resv_nxt     = resv_r;
    hint_nxt     = hint_r;
    free_nxt     = free_r;
    cur_nxt      = cur_r;
    issued_nxt   = issued_r;
    chk_vld_nxt  = 1'b0;
    chk_addr_nxt = chk_addr_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    res_blk_nxt  = res_blk_r;
    res_st_nxt   = res_st_r;
    out_blk_nxt  = out_blk_r;
    out_st_nxt   = out_st_r;
    out_cnt_nxt  = out_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en   = 1'b0;
    rd_addr = cur_r;
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = '0;

    if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL:    total_nxt = cfg_data;
        REG_RESERVED: resv_nxt  = cfg_data[RES_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        cur_nxt = cur_r + WORD_AW'(1);
        if (cur_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_blk_nxt = '0;
          res_st_nxt  = ST_OK;
          first_nxt   = in_block_number;
          last_nxt    = run_last;
          state_nxt   = S_FIN;
          case (in_mode)
            MODE_ALLOC: begin
              if (free_r == '0) begin
                res_st_nxt = ST_NOSPACE;
              end else begin
                cur_nxt    = {hint_r[BLK_W-1 -: GRP_AW], {GW_AW{1'b0}}};
                issued_nxt = '0;
                state_nxt  = S_SCAN;
              end
            end
            MODE_FREE: begin
              if (in_block_number == '0 || run_end > eff) begin
                res_st_nxt = ST_RANGE;
              end else begin
                free_nxt = (free_sum > eff) ? eff : free_sum;
                if (hint_r > in_block_number) begin
                  hint_nxt = in_block_number;
                end
                if (in_run_length != '0) begin
                  cur_nxt   = in_block_number[BLK_W-1:BIT_AW];
                  state_nxt = S_FRD;
                end
              end
            end
            MODE_FORMAT: begin
              free_nxt  = (CNT_W'(resv_r) < eff) ? (eff - CNT_W'(resv_r)) : '0;
              hint_nxt  = '0;
              cur_nxt   = '0;
              state_nxt = S_FMT;
            end
            default: ;
          endcase
        end
      end
      S_FMT: begin
        wr_en   = 1'b1;
        wr_data = fmt_word;
        cur_nxt = cur_r + WORD_AW'(1);
        if (cur_r == LAST_WORD) begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (chk_vld_r && rd_data_r != '1) begin
          // first word with room: take its lowest clear bit
          wr_en       = 1'b1;
          wr_addr     = chk_addr_r;
          wr_data     = rd_data_r | (word_t'(1) << zbit);
          res_blk_nxt = {chk_addr_r, zbit};
          hint_nxt    = {chk_addr_r, zbit} + BLK_W'(1);
          free_nxt    = free_r - CNT_W'(1);
          state_nxt   = S_FIN;
        end else if (chk_vld_r && issued_r == ALL_WORDS) begin
          res_st_nxt = ST_NOSPACE;
          state_nxt  = S_FIN;
        end else if (issued_r != ALL_WORDS) begin
          rd_en        = 1'b1;
          rd_addr      = cur_r;
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = cur_r;
          cur_nxt      = cur_r + WORD_AW'(1);
          issued_nxt   = issued_r + (WORD_AW+1)'(1);
        end
      end
      S_FRD: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r & ~clr_mask;
        if (cur_r == last_r[BLK_W-1:BIT_AW]) begin
          state_nxt = S_FIN;
        end else begin
          cur_nxt   = cur_r + WORD_AW'(1);
          state_nxt = S_FRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = free_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      total_r     <= TOTAL_RESET;
      resv_r      <= '0;
      hint_r      <= '0;
      free_r      <= '0;
      cur_r       <= '0;
      issued_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      resv_r      <= resv_nxt;
      hint_r      <= hint_nxt;
      free_r      <= free_nxt;
      cur_r       <= cur_nxt;
      issued_r    <= issued_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    res_blk_r  <= res_blk_nxt;
    res_st_r   <= res_st_nxt;
    out_blk_r  <= out_blk_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_blk_r;
  assign out_status          = out_st_r;
  assign out_free_count      = out_cnt_r;

endmodule

[tb/bba_result_checker.sv]
`timescale 1ns / 1ps

module bba_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bba_pkg::CIDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [bba_pkg::MODE_W-1:0] in_mode,
  input  logic [bba_pkg::BLK_W-1:0]  in_block_number,
  input  logic [bba_pkg::LEN_W-1:0]  in_run_length,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bba_pkg::BLK_W-1:0]  out_allocated_block,
  input  logic [bba_pkg::ST_W-1:0]   out_status,
  input  logic [bba_pkg::CNT_W-1:0]  out_free_count,
  output int                         pending,
  output int                         fail_count
);
  import bba_pkg::*;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] free_count;
  } alloc_result_t;

  localparam int GROUP_BITS = GROUP_WORDS * WORD_BITS;

  word_t            usage_map [MAP_WORDS];
  logic [BLK_W-1:0] hint;
  logic [CNT_W-1:0] free_left;
  logic [CNT_W-1:0] total_reg;
  logic [RES_W-1:0] reserved_reg;
  alloc_result_t    expected_results [$];
  int               mismatches;

  function automatic int usable_total();
    return (int'(total_reg) < MAP_BITS) ? int'(total_reg) : MAP_BITS;
  endfunction

  function automatic void predict_format();
    int eff;
    eff = usable_total();
    for (int b = 0; b < MAP_BITS; b++)
      usage_map[b / WORD_BITS][b % WORD_BITS] = (b < int'(reserved_reg)) || (b >= eff);
    free_left = (int'(reserved_reg) < eff) ? CNT_W'(eff - int'(reserved_reg)) : '0;
    hint = '0;
  endfunction

  function automatic void predict_alloc(output logic [BLK_W-1:0] granted,
                                        output logic [ST_W-1:0] st);
    int start, g, idx, b, blk;
    bit found;
    granted = '0;
    st = ST_NOSPACE;
    found = 0;
    idx = 0;
    if (free_left == 0) return;
    start = (int'(hint) / GROUP_BITS) % MAP_GROUPS;
    g = start;
    do begin
      for (int w = 0; w < GROUP_WORDS && !found; w++) begin
        if (usage_map[g * GROUP_WORDS + w] != '1) begin
          idx = g * GROUP_WORDS + w;
          found = 1;
        end
      end
      if (!found) g = (g + 1) % MAP_GROUPS;
    end while (!found && g != start);
    if (!found) return;
    b = 0;
    while (usage_map[idx][b]) b++;
    usage_map[idx][b] = 1'b1;
    blk = idx * WORD_BITS + b;
    hint = BLK_W'((blk + 1) % MAP_BITS);
    free_left = free_left - 1'b1;
    granted = BLK_W'(blk);
    st = ST_OK;
  endfunction

  function automatic logic [ST_W-1:0] predict_free(int first, int len);
    int eff, total_sum;
    eff = usable_total();
    if (first == 0 || first + len > eff) return ST_RANGE;
    for (int b = first; b < first + len; b++)
      usage_map[b / WORD_BITS][b % WORD_BITS] = 1'b0;
    total_sum = int'(free_left) + len;
    free_left = CNT_W'((total_sum > eff) ? eff : total_sum);
    if (int'(hint) > first) hint = BLK_W'(first);
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    logic [BLK_W-1:0] granted;
    logic [ST_W-1:0]  st;
    if (!rst_n) begin
      foreach (usage_map[i]) usage_map[i] = '0;
      hint = '0;
      free_left = '0;
      total_reg = TOTAL_RESET;
      reserved_reg = '0;
      expected_results.delete();
      mismatches = 0;
      pending <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL) total_reg = cfg_data;
        else if (cfg_index == REG_RESERVED) reserved_reg = cfg_data[RES_W-1:0];
      end
      if (in_valid && !in_stall) begin
        granted = '0;
        st = ST_OK;
        case (in_mode)
          MODE_ALLOC:  predict_alloc(granted, st);
          MODE_FREE:   st = predict_free(int'(in_block_number), int'(in_run_length));
          MODE_FORMAT: predict_format();
          default: ;
        endcase
        expected_results.push_back('{granted, st, free_left});
      end
      if (out_valid && !out_stall) begin
        got = '{out_allocated_block, out_status, out_free_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: block %0d status %0d free %0d",
                     got.block, got.status, got.free_count);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp block %0d status %0d free %0d, got %0d %0d %0d",
                       exp_r.block, exp_r.status, exp_r.free_count,
                       got.block, got.status, got.free_count);
          end
        end
      end
      pending <= expected_results.size();
      fail_count <= mismatches;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode;
  logic [BLK_W-1:0]  in_block_number;
  logic [LEN_W-1:0]  in_run_length;
  logic              out_valid;
  logic              out_stall;
  logic [BLK_W-1:0]  out_allocated_block;
  logic [ST_W-1:0]   out_status;
  logic [CNT_W-1:0]  out_free_count;
  int                pending;
  int                fail_count;

  int cur_total;
  int burst_left;
  int stall_left;
  int stall_pct;
  int idle_cycles;

  block_bitmap_allocator dut (.*);

  bba_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stall pattern: stretches of no stall, light and heavy stall
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_pct <= 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left <= $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          default: stall_pct <= 85;
        endcase
      end else begin
        stall_left <= stall_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(logic [MODE_W-1:0] mode, int blk, int len);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_block_number <= BLK_W'(blk);
    in_run_length <= LEN_W'(len);
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(int total, int reserved);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_TOTAL;
    cfg_data <= CNT_W'(total);
    @(posedge clk);
    cfg_index <= REG_RESERVED;
    cfg_data <= CNT_W'(reserved);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_total = total;
  endtask

  task automatic random_requests(int count);
    int eff, blk, len, pick;
    eff = (cur_total < MAP_BITS) ? cur_total : MAP_BITS;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_req(MODE_ALLOC, $urandom_range(0, 131071), $urandom_range(0, 8191));
      end else if (pick < 88 && eff > 1) begin
        blk = $urandom_range(1, eff - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 40);
        if (blk + len > eff) len = eff - blk;
        send_req(MODE_FREE, blk, len);
      end else if (pick < 95) begin
        // broken frees: block zero or running off the end
        blk = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 131071);
        send_req(MODE_FREE, blk, $urandom_range(0, 8191));
      end else if (pick < 97) begin
        send_req(MODE_FORMAT, $urandom_range(0, 131071), $urandom_range(0, 8191));
      end else begin
        send_req(MODE_UNUSED, $urandom_range(0, 131071), $urandom_range(0, 8191));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TOTAL;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_mode <= MODE_ALLOC;
    in_block_number <= '0;
    in_run_length <= '0;
    burst_left = 0;
    cur_total = MAP_BITS;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any format: no space
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_FREE, 131071, 1);
    set_regs(131072, 0);
    send_req(MODE_FORMAT, 0, 0);
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_ALLOC, 131071, 8191);
    send_req(MODE_FREE, 0, 1);
    send_req(MODE_FREE, 5, 0);
    send_req(MODE_FREE, 131071, 2);
    send_req(MODE_FREE, 1, 4096);
    send_req(MODE_FREE, 126976, 4096);
    send_req(MODE_UNUSED, 131071, 8191);
    send_req(MODE_ALLOC, 0, 0);

    // tiny disk: fill the map, then double free leaves count above real space
    set_regs(64, 0);
    send_req(MODE_FORMAT, 0, 0);
    for (int i = 0; i < 64; i++) send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_FREE, 5, 1);
    send_req(MODE_FREE, 5, 1);
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_ALLOC, 0, 0);
    send_req(MODE_FREE, 1, 64);

    set_regs(100, 4096);
    send_req(MODE_FORMAT, 0, 0);
    send_req(MODE_ALLOC, 0, 0);
    random_requests(60);

    set_regs(1, 0);
    send_req(MODE_FORMAT, 0, 0);
    random_requests(40);

    set_regs(131072, 4096);
    send_req(MODE_FORMAT, 0, 0);
    random_requests(180);

    set_regs(5000, 37);
    send_req(MODE_FORMAT, 0, 0);
    random_requests(170);

    set_regs(262143, 0);
    send_req(MODE_FORMAT, 0, 0);
    random_requests(170);

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/bba_pkg.sv
design/block_bitmap_allocator.sv
tb/bba_result_checker.sv
tb/testbench.sv
